// ===== sv/plur_pkg.sv =====
package plur_pkg;

    // Field widths
    localparam int IDX_W    = 17;
    localparam int COLOUR_W = 16;
    localparam int COORD_W  = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Source limits compare at this width (parameter range up to 2047)
    localparam int LIMIT_W = 11;
    // Span edge input k = line or line + 1
    localparam int K_W = COORD_W + 1;
    // Span edge numerator k*N + D-1 and quotient width
    localparam int EDGE_W = 12;
    // Reciprocal divide: q = (num * floor(2^S / D)) >> S, then one correction
    localparam int RECIP_SHIFT = 13;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Destination spans are cut to this many pixels
    localparam logic [1:0] SPAN_MAX = 2'd2;

    // Placement on the display
    localparam logic [IDX_W-1:0] COL_BASE_90  = IDX_W'(3 + 234 - 1);
    localparam logic [IDX_W-1:0] COL_BASE_270 = IDX_W'(3);
    localparam logic [IDX_W-1:0] ROW_BASE_90  = IDX_W'(30);
    localparam logic [IDX_W-1:0] ROW_BASE_270 = IDX_W'(30 + 260 - 1);

    // Register map (word index = paddr[4:2])
    localparam logic [2:0] REG_ROTATE = 3'd0;
    localparam logic [2:0] REG_SHADE0 = 3'd1;
    localparam logic [2:0] REG_SHADE1 = 3'd2;
    localparam logic [2:0] REG_SHADE2 = 3'd3;
    localparam logic [2:0] REG_SHADE3 = 3'd4;

    // Palette reset values
    localparam logic [COLOUR_W-1:0] SHADE0_RESET = 16'hFFFF;
    localparam logic [COLOUR_W-1:0] SHADE1_RESET = 16'hAD55;
    localparam logic [COLOUR_W-1:0] SHADE2_RESET = 16'h52AA;
    localparam logic [COLOUR_W-1:0] SHADE3_RESET = 16'h0000;

    typedef struct packed {
        logic [COORD_W-1:0] src_line;
        logic [COORD_W-1:0] src_column;
        logic [COORD_W-1:0] shade_code;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0]    write_index;
        logic [COLOUR_W-1:0] write_colour;
        logic                last_write;
    } result_t;

    // One placed pixel block handed to the output queue
    typedef struct packed {
        logic                       valid;
        logic [1:0][IDX_W-1:0]      row_base;
        logic [1:0][IDX_W-1:0]      col;
        logic [1:0]                 ny;
        logic [1:0]                 nx;
        logic [COLOUR_W-1:0]        colour;
    } plur_job_t;

endpackage

// ===== sv/plur_edge.sv =====
module plur_edge #(
    parameter int SCALE_NUM = 13,
    parameter int SCALE_DEN = 8
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [plur_pkg::K_W-1:0]    k,
    output logic [plur_pkg::EDGE_W-1:0] span_edge
);
    import plur_pkg::*;

    localparam int RECIP = (1 << RECIP_SHIFT) / SCALE_DEN;
    localparam logic [3:0]         NUM_C   = 4'(SCALE_NUM);
    localparam logic [3:0]         DEN_C   = 4'(SCALE_DEN);
    localparam logic [EDGE_W-1:0]  BIAS_C  = EDGE_W'(SCALE_DEN - 1);
    localparam logic [EDGE_W-1:0]  DEN_E   = EDGE_W'(SCALE_DEN);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic [EDGE_W-1:0]         num_reg;
    logic [EDGE_W-1:0]         num2_reg;
    logic [EDGE_W-1:0]         quot_reg;
    logic [EDGE_W-1:0]         edge_reg;
    logic [EDGE_W-1:0]         num_next;
    logic [EDGE_W-1:0]         quot_next;
    logic [EDGE_W-1:0]         edge_next;
    logic [K_W+3:0]            scaled;
    logic [EDGE_W+RECIP_W-1:0] recip_prod;
    logic [EDGE_W+3:0]         back_prod;
    logic [EDGE_W-1:0]         rem;

    // Stage 1: numerator k*N + D-1
    assign scaled   = {4'd0, k} * {{K_W{1'b0}}, NUM_C};
    assign num_next = EDGE_W'(scaled) + BIAS_C;

    // Stage 2: quotient estimate, low by at most one
    assign recip_prod = {{RECIP_W{1'b0}}, num_reg} * {{EDGE_W{1'b0}}, RECIP_C};
    assign quot_next  = EDGE_W'(recip_prod >> RECIP_SHIFT);

    // Stage 3: remainder check and correction
    assign back_prod = {4'd0, quot_reg} * {{EDGE_W{1'b0}}, DEN_C};
    assign rem       = num2_reg - EDGE_W'(back_prod);
    assign edge_next = (rem >= DEN_E) ? quot_reg + EDGE_W'(1) : quot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            num2_reg <= num_reg;
            quot_reg <= quot_next;
            edge_reg <= edge_next;
        end
    end

    assign span_edge = edge_reg;

endmodule

// ===== sv/plur_out.sv =====
module plur_out (
    input  logic                clk,
    input  logic                rst_n,
    input  plur_pkg::plur_job_t job,
    output logic                take,
    output logic                result_strobe,
    output plur_pkg::result_t   result
);
    import plur_pkg::*;

    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic [IDX_W-1:0]    list_reg [4];
    logic [IDX_W-1:0]    list_new [4];
    logic [COLOUR_W-1:0] colour_reg;
    logic                res_valid_reg;
    result_t             res_reg;
    logic [2:0]          n_new;
    logic                load;
    logic                emit;
    logic [IDX_W-1:0]    s00, s01, s10, s11;

    // Queue can take a new block while it holds at most its final word
    assign take = (cnt_reg <= 3'd1);
    assign load = job.valid && take;
    assign emit = (cnt_reg != 3'd0);

    // Indices of the block, rows of the display by x, columns by y
    assign s00 = job.row_base[0] + job.col[0];
    assign s01 = job.row_base[1] + job.col[0];
    assign s10 = job.row_base[0] + job.col[1];
    assign s11 = job.row_base[1] + job.col[1];

    assign n_new = 3'({1'b0, job.ny} * {1'b0, job.nx});

    // y outer, x inner
    always_comb
    begin
        if (job.nx == SPAN_MAX)
        begin
            list_new[0] = s00;
            list_new[1] = s01;
            list_new[2] = s10;
            list_new[3] = s11;
        end
        else
        begin
            list_new[0] = s00;
            list_new[1] = s10;
            list_new[2] = s10;
            list_new[3] = s11;
        end
    end

    always_comb
    begin
        if (load)
            cnt_next = n_new;
        else if (emit)
            cnt_next = cnt_reg - 3'd1;
        else
            cnt_next = cnt_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            res_valid_reg <= emit;
        end
    end

    // Word queue and output word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg.write_index  <= list_reg[0];
            res_reg.write_colour <= colour_reg;
            res_reg.last_write   <= (cnt_reg == 3'd1);
        end
        if (load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                list_reg[i] <= list_new[i];
            end
            colour_reg <= job.colour;
        end
        else if (emit)
        begin
            list_reg[0] <= list_reg[1];
            list_reg[1] <= list_reg[2];
            list_reg[2] <= list_reg[3];
        end
    end

    assign result_strobe = res_valid_reg;
    assign result        = res_reg;

`ifndef SYNTHESIS
    // A word that is not the last leaves more queued behind it
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.last_write |-> cnt_reg != 3'd0)
        else $error("non-final word left an empty queue");

    // Queued words drain one per cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 3'd0 |=> res_valid_reg)
        else $error("queued word not sent");

    // Last flag only on the final queued word
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.last_write |-> $past(cnt_reg) == 3'd1)
        else $error("last flag on a word that was not final");
`endif

endmodule

// ===== sv/pixel_line_upscale_rotate_top.sv =====
// A pixel passes the input, span edge, placement, job, queue and output word registers;
// its words follow one per cycle (a pixel gives 1, 2 or 4 words at the default scale).
// Throughput: one word per cycle; a new pixel each cycle when the output queue holds
// at most its final word; a 4-word pixel can stall input on the single result port.
// Reset: rst_n clears the pipeline and queue and loads the palette and rotation defaults.
module pixel_line_upscale_rotate_top #(
    parameter int SRC_WIDTH      = 160,
    parameter int SRC_HEIGHT     = 144,
    parameter int SCALE_NUM      = 13,
    parameter int SCALE_DEN      = 8,
    parameter int DISPLAY_STRIDE = 240
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  plur_pkg::pixel_t            pixel,
    output logic                        result_strobe,
    output plur_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plur_pkg::ADDR_W-1:0] paddr,
    input  logic [plur_pkg::DATA_W-1:0] pwdata,
    output logic [plur_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import plur_pkg::*;

    localparam int STRIDE_W = $clog2(DISPLAY_STRIDE + 1);
    localparam logic [STRIDE_W-1:0] STRIDE_C = STRIDE_W'(DISPLAY_STRIDE);
    localparam logic [LIMIT_W-1:0]  HEIGHT_C = LIMIT_W'(SRC_HEIGHT);
    localparam logic [LIMIT_W-1:0]  WIDTH_C  = LIMIT_W'(SRC_WIDTH);
    localparam int E_YS = 0;
    localparam int E_YE = 1;
    localparam int E_XS = 2;
    localparam int E_XE = 3;

    // Configuration registers
    logic                rotate_reg;
    logic [COLOUR_W-1:0] shade0_reg, shade1_reg, shade2_reg, shade3_reg;
    logic                cfg_write;

    // Pipeline
    logic                adv;
    logic                accept;
    logic                in_range;
    logic [COLOUR_W-1:0] colour_sel;
    logic                s1_valid_reg;
    logic [COORD_W-1:0]  s1_line_reg, s1_col_reg;
    logic [COLOUR_W-1:0] s1_colour_reg;
    logic [2:0]          edge_valid_reg;
    logic [COLOUR_W-1:0] edge_colour_reg [3];
    logic [K_W-1:0]      edge_k [4];
    logic [EDGE_W-1:0]   span_edge [4];
    logic                s5_valid_reg;
    logic [1:0]          s5_ny_reg, s5_nx_reg;
    logic [1:0]          ny_next, nx_next;
    logic [IDX_W-1:0]    s5_col_reg [2];
    logic [IDX_W-1:0]    s5_row_reg [2];
    logic [IDX_W-1:0]    col_next [2];
    logic [IDX_W-1:0]    row_next [2];
    logic [COLOUR_W-1:0] s5_colour_reg;
    logic [EDGE_W-1:0]   dy, dx;
    logic [IDX_W-1:0]    ys_w, xs_w;
    logic [IDX_W+STRIDE_W-1:0] row_prod [2];
    logic                  job_valid_reg;
    logic [1:0][IDX_W-1:0] job_row_reg;
    logic [1:0][IDX_W-1:0] job_col_reg;
    logic [1:0]            job_ny_reg, job_nx_reg;
    logic [COLOUR_W-1:0]   job_colour_reg;
    plur_job_t             job;
    logic                take;

    // Register writes and reads
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_reg <= 1'b0;
            shade0_reg <= SHADE0_RESET;
            shade1_reg <= SHADE1_RESET;
            shade2_reg <= SHADE2_RESET;
            shade3_reg <= SHADE3_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_ROTATE: rotate_reg <= pwdata[0];
                REG_SHADE0: shade0_reg <= pwdata[COLOUR_W-1:0];
                REG_SHADE1: shade1_reg <= pwdata[COLOUR_W-1:0];
                REG_SHADE2: shade2_reg <= pwdata[COLOUR_W-1:0];
                REG_SHADE3: shade3_reg <= pwdata[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_ROTATE: prdata = {{(DATA_W-1){1'b0}}, rotate_reg};
            REG_SHADE0: prdata = {{(DATA_W-COLOUR_W){1'b0}}, shade0_reg};
            REG_SHADE1: prdata = {{(DATA_W-COLOUR_W){1'b0}}, shade1_reg};
            REG_SHADE2: prdata = {{(DATA_W-COLOUR_W){1'b0}}, shade2_reg};
            REG_SHADE3: prdata = {{(DATA_W-COLOUR_W){1'b0}}, shade3_reg};
            default:    prdata = '0;
        endcase
    end

    // Whole pipeline moves when the last stage is empty or the queue takes it
    assign adv    = !job_valid_reg || take;
    assign busy   = !adv;
    assign accept = start && !busy;

    // Input stage: range check and palette lookup
    assign in_range = ({3'd0, pixel.src_line} < HEIGHT_C) &&
                      ({3'd0, pixel.src_column} < WIDTH_C);

    always_comb
    begin
        case (pixel.shade_code[1:0])
            2'd0:    colour_sel = shade0_reg;
            2'd1:    colour_sel = shade1_reg;
            2'd2:    colour_sel = shade2_reg;
            default: colour_sel = shade3_reg;
        endcase
    end

    // Span edges ceil(k*N/D), three stages each
    assign edge_k[E_YS] = {1'b0, s1_line_reg};
    assign edge_k[E_YE] = {1'b0, s1_line_reg} + K_W'(1);
    assign edge_k[E_XS] = {1'b0, s1_col_reg};
    assign edge_k[E_XE] = {1'b0, s1_col_reg} + K_W'(1);

    for (genvar g = 0; g < 4; g++)
    begin : g_edge
        plur_edge #(
            .SCALE_NUM (SCALE_NUM),
            .SCALE_DEN (SCALE_DEN)
        ) u_edge (
            .clk       (clk),
            .en        (adv),
            .k         (edge_k[g]),
            .span_edge (span_edge[g])
        );
    end

    // Span lengths and placement
    assign dy   = span_edge[E_YE] - span_edge[E_YS];
    assign dx   = span_edge[E_XE] - span_edge[E_XS];
    assign ys_w = IDX_W'(span_edge[E_YS]);
    assign xs_w = IDX_W'(span_edge[E_XS]);

    always_comb
    begin
        ny_next = (dy >= EDGE_W'(SPAN_MAX)) ? SPAN_MAX : dy[1:0];
        nx_next = (dx >= EDGE_W'(SPAN_MAX)) ? SPAN_MAX : dx[1:0];
        for (int j = 0; j < 2; j++)
        begin
            if (rotate_reg)
            begin
                col_next[j] = COL_BASE_270 + ys_w + IDX_W'(j);
                row_next[j] = ROW_BASE_270 - xs_w - IDX_W'(j);
            end
            else
            begin
                col_next[j] = COL_BASE_90 - ys_w - IDX_W'(j);
                row_next[j] = ROW_BASE_90 + xs_w + IDX_W'(j);
            end
        end
    end

    // Row start offsets, modulo the index width
    assign row_prod[0] = {{STRIDE_W{1'b0}}, s5_row_reg[0]} * {{IDX_W{1'b0}}, STRIDE_C};
    assign row_prod[1] = {{STRIDE_W{1'b0}}, s5_row_reg[1]} * {{IDX_W{1'b0}}, STRIDE_C};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            edge_valid_reg <= 3'd0;
            s5_valid_reg   <= 1'b0;
            job_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg   <= accept && in_range;
            edge_valid_reg <= {edge_valid_reg[1:0], s1_valid_reg};
            s5_valid_reg   <= edge_valid_reg[2];
            job_valid_reg  <= s5_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_line_reg        <= pixel.src_line;
            s1_col_reg         <= pixel.src_column;
            s1_colour_reg      <= colour_sel;
            edge_colour_reg[0] <= s1_colour_reg;
            edge_colour_reg[1] <= edge_colour_reg[0];
            edge_colour_reg[2] <= edge_colour_reg[1];
            s5_ny_reg          <= ny_next;
            s5_nx_reg          <= nx_next;
            s5_col_reg[0]      <= col_next[0];
            s5_col_reg[1]      <= col_next[1];
            s5_row_reg[0]      <= row_next[0];
            s5_row_reg[1]      <= row_next[1];
            s5_colour_reg      <= edge_colour_reg[2];
            job_row_reg[0]     <= IDX_W'(row_prod[0]);
            job_row_reg[1]     <= IDX_W'(row_prod[1]);
            job_col_reg[0]     <= s5_col_reg[0];
            job_col_reg[1]     <= s5_col_reg[1];
            job_ny_reg         <= s5_ny_reg;
            job_nx_reg         <= s5_nx_reg;
            job_colour_reg     <= s5_colour_reg;
        end
    end

    // Placed block handed to the queue
    assign job = '{valid:    job_valid_reg,
                   row_base: job_row_reg,
                   col:      job_col_reg,
                   ny:       job_ny_reg,
                   nx:       job_nx_reg,
                   colour:   job_colour_reg};

    // Output queue, one word per cycle
    plur_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .take          (take),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ===== dv/tb_pixel_line_upscale_rotate_top.sv =====
module tb_pixel_line_upscale_rotate_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plur_pkg::*;

    // Geometry of the default build
    localparam int unsigned SRC_W     = 160;
    localparam int unsigned SRC_H     = 144;
    localparam int unsigned SCALE_NUM = 13;
    localparam int unsigned SCALE_DEN = 8;
    localparam int unsigned STRIDE    = 240;
    localparam int unsigned AREA_X    = 3;
    localparam int unsigned AREA_Y    = 30;
    localparam int unsigned AREA_W    = 260;
    localparam int unsigned AREA_H    = 234;
    localparam int unsigned SPAN_CAP  = 2;

    // Settle time after the last expected word
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 5000;

    // Field extremes, every shade code, high shade bits and out-of-area pixels
    localparam int NUM_CORNERS = 13;
    localparam pixel_t CORNER_PIXELS [NUM_CORNERS] = '{
        '{8'd0,   8'd0,   8'h00},
        '{8'd143, 8'd159, 8'h03},
        '{8'd0,   8'd159, 8'h01},
        '{8'd143, 8'd0,   8'h02},
        '{8'd1,   8'd1,   8'hFC},
        '{8'd2,   8'd5,   8'hFF},
        '{8'd144, 8'd10,  8'h01},
        '{8'd10,  8'd160, 8'h01},
        '{8'd255, 8'd255, 8'hAA},
        '{8'd200, 8'd0,   8'h55},
        '{8'd7,   8'd7,   8'h80},
        '{8'd0,   8'd255, 8'h01},
        '{8'd128, 8'd128, 8'h7E}
    };

    // Predicts the framebuffer write words of each accepted pixel and checks them
    class upscale_scoreboard;
        logic                rotate_270;
        logic [COLOUR_W-1:0] palette [4];
        result_t             pending_writes [$];
        int                  pixels_seen;
        int                  writes_checked;
        int                  errors;

        function new();
            rotate_270 = 1'b0;
            palette[0] = SHADE0_RESET;
            palette[1] = SHADE1_RESET;
            palette[2] = SHADE2_RESET;
            palette[3] = SHADE3_RESET;
            pixels_seen = 0;
            writes_checked = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ROTATE: rotate_270 = value[0];
                REG_SHADE0: palette[0] = value[COLOUR_W-1:0];
                REG_SHADE1: palette[1] = value[COLOUR_W-1:0];
                REG_SHADE2: palette[2] = value[COLOUR_W-1:0];
                REG_SHADE3: palette[3] = value[COLOUR_W-1:0];
                default: ;
            endcase
        endfunction

        // First destination pixel covered by source coordinate k: ceil(k*N/D)
        function int unsigned scaled_start(int unsigned k);
            return (k * SCALE_NUM + SCALE_DEN - 1) / SCALE_DEN;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        function void note_pixel(pixel_t p);
            int unsigned line;
            int unsigned col;
            int unsigned ys;
            int unsigned ye;
            int unsigned xs;
            int unsigned xe;
            int unsigned dcol;
            int unsigned drow;
            int unsigned idx;
            result_t     w;
            line = p.src_line;
            col  = p.src_column;
            pixels_seen++;
            // pixels outside the source area give no words
            if (line >= SRC_H || col >= SRC_W)
                return;
            ys = scaled_start(line);
            ye = scaled_start(line + 1);
            xs = scaled_start(col);
            xe = scaled_start(col + 1);
            if (ye - ys > SPAN_CAP)
                ye = ys + SPAN_CAP;
            if (xe - xs > SPAN_CAP)
                xe = xs + SPAN_CAP;
            // rows of the source axis outer, columns inner
            for (int unsigned sy = ys; sy < ye; sy++)
            begin
                dcol = rotate_270 ? AREA_X + sy : AREA_X + AREA_H - 1 - sy;
                for (int unsigned sx = xs; sx < xe; sx++)
                begin
                    drow = rotate_270 ? AREA_Y + AREA_W - 1 - sx : AREA_Y + sx;
                    idx = drow * STRIDE + dcol;
                    w.write_index  = idx[IDX_W-1:0];
                    w.write_colour = palette[p.shade_code[1:0]];
                    w.last_write   = (sy == ye - 1) && (sx == xe - 1);
                    pending_writes.push_back(w);
                end
            end
        endfunction

        function void check_write(result_t r);
            result_t exp;
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write word: index %0d colour %h last %0d",
                       r.write_index, r.write_colour, r.last_write);
                errors++;
                return;
            end
            exp = pending_writes.pop_front();
            writes_checked++;
            if (r.write_index !== exp.write_index)
            begin
                $error("write_index: expected %0d, got %0d", exp.write_index, r.write_index);
                errors++;
            end
            if (r.write_colour !== exp.write_colour)
            begin
                $error("write_colour: expected %h, got %h", exp.write_colour, r.write_colour);
                errors++;
            end
            if (r.last_write !== exp.last_write)
            begin
                $error("last_write: expected %0d, got %0d", exp.last_write, r.last_write);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    pixel_t              pixel;
    logic                result_strobe;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    upscale_scoreboard sb;
    int                reg_writes;

    pixel_line_upscale_rotate_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel         (pixel),
        .result_strobe (result_strobe),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("tb_pixel_line_upscale_rotate_top failed");
        $finish;
    end

    // Write word monitor; the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_write(result);
    end

    // One APB write: setup and access phases, then psel and penable drop back to idle
    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(logic [DATA_W-1:0] rot, logic [DATA_W-1:0] c0,
                                logic [DATA_W-1:0] c1, logic [DATA_W-1:0] c2,
                                logic [DATA_W-1:0] c3);
        write_reg(REG_ROTATE, rot);
        write_reg(REG_SHADE0, c0);
        write_reg(REG_SHADE1, c1);
        write_reg(REG_SHADE2, c2);
        write_reg(REG_SHADE3, c3);
    endtask

    // Offer one pixel after an optional random gap; returns at the accepting edge
    task automatic send_pixel(pixel_t p, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    // Drop start, wait for every expected word, then let the pipeline settle
    task automatic drain();
        int i;
        start <= 1'b0;
        for (i = 0; i < DRAIN_LIMIT && sb.pending() > 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_corners();
        for (int i = 0; i < NUM_CORNERS; i++)
            send_pixel(CORNER_PIXELS[i], 0);
        drain();
    endtask

    // Mostly in-area pixels, about one in ten drawn from the whole field range
    task automatic send_random(int count, int idle_pct);
        pixel_t p;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                p.src_line   = 8'($urandom_range(255));
                p.src_column = 8'($urandom_range(255));
            end
            else
            begin
                p.src_line   = 8'($urandom_range(SRC_H - 1));
                p.src_column = 8'($urandom_range(SRC_W - 1));
            end
            p.shade_code = 8'($urandom_range(255));
            send_pixel(p, idle_pct);
        end
        drain();
    endtask

    // Main sequence
    initial
    begin
        sb         = new();
        reg_writes = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        pixel      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset palette, 90 degree placement
        send_corners();

        // 270 degree placement, palette extremes, upper data bits set
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom);
        send_corners();
        send_random(135, 0);

        // back to 90 degrees with a random palette, sparse sender
        program_regs(32'hFFFF_FFFE, $urandom, $urandom, $urandom, $urandom);
        send_random(135, 77);

        // 270 degrees, alternating extreme colours, light gaps
        program_regs(32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0);
        send_random(135, 6);

        if (sb.pending() > 0)
        begin
            $error("%0d expected write words never arrived", sb.pending());
            sb.errors += sb.pending();
        end

        $display("Covered %0d pixels and %0d write words across both rotations,",
                 sb.pixels_seen, sb.writes_checked);
        $display("with %0d register writes and gap-free, sparse and light-gap input.",
                 reg_writes);
        if (sb.errors == 0)
            $display("tb_pixel_line_upscale_rotate_top passed");
        else
            $display("tb_pixel_line_upscale_rotate_top failed");
        $finish;
    end

endmodule
